/* design/lrstb_pkg.sv */
// Shared types and constants for the LED row-scan triple-buffer controller.
package lrstb_pkg;

  localparam int ROW_W    = 4;
  localparam int BUF_W    = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_UPDATE    = 3'd1,
    OP_LATCH     = 3'd2,
    OP_DMA_IDLE  = 3'd3,
    OP_SWAP_REQ  = 3'd4,
    OP_DETECT    = 3'd5,
    OP_DMA_RESET = 3'd6,
    OP_DRAW      = 3'd7
  } opcode_t;

  typedef enum logic [3:0] {
    ST_SWITCH_EN       = 4'd0,
    ST_SWITCH_EN_WAIT  = 4'd1,
    ST_IDLE            = 4'd2,
    ST_LOD             = 4'd3,
    ST_LOD_SWITCH      = 4'd4,
    ST_LOD_SWITCH_WAIT = 4'd5,
    ST_LOD_ADVANCE     = 4'd6,
    ST_LOD_SETTLE      = 4'd7,
    ST_LOD_ERROR       = 4'd8
  } seq_state_t;

  localparam logic [1:0] DRV_ENABLED = 2'd1;
  localparam logic [1:0] DRV_DETECT  = 2'd2;

  localparam logic [1:0] MREQ_NONE    = 2'd0;
  localparam logic [1:0] MREQ_ENABLED = 2'd1;
  localparam logic [1:0] MREQ_DETECT  = 2'd2;

  localparam logic [1:0] TREQ_NONE   = 2'd0;
  localparam logic [1:0] TREQ_SETTLE = 2'd1;
  localparam logic [1:0] TREQ_ERROR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERLACED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_SWAP  = 2'd1;

endpackage

/* design/led_row_scan_triple_buffer_ctrl.sv */
// Top level: event-driven row scan, triple-buffer rotation and open-LED detect sequencer.
//
// Each accepted input item is one event (tick, update, latch, DMA idle, swap request,
// detect start, DMA reset, pixel write) and yields exactly one result item. The event
// is decoded and all state is updated in the accept cycle; the result is captured in the
// output register at the same clock edge. One item per clock is sustained: in_tready stays
// high while the output register is empty or being drained, so throughput is set only
// by the single output register stage. Configuration writes (interlaced, auto_swap)
// are always taken and should be issued while no result is outstanding.
module led_row_scan_triple_buffer_ctrl
  import lrstb_pkg::*;
#(
  parameter int ROWS    = 16,
  parameter int COLUMNS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] driver_mode, [2] timer_expired, [3] lod_error, [11:4] pixel_x,
  // [19:12] pixel_y, [27:20] pixel_red, [35:28] pixel_green, [43:36] pixel_blue
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] opcode
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] row_enable, [17:16] display_buffer, [19:18] receive_buffer,
  // [27:20] row_data_offset, [35:28] pixel_address, [59:36] pixel_data,
  // [61:60] mode_request, [63:62] timer_request, [64] dma_arm, [65] accepted,
  // [66] busy_res
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic                  cfg_data
);

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [ROW_W-1:0] HALF     = ROW_W'(ROWS / 2);
  localparam logic [7:0]       MAX_X    = 8'(COLUMNS - 1);
  localparam logic [7:0]       MAX_Y    = 8'(ROWS - 1);

  logic interlaced_r, auto_swap_r;
  seq_state_t seq_r, seq_nxt;
  logic dma_phase_r, dma_phase_nxt;
  logic sched_r, sched_nxt, pend_r, pend_nxt;
  logic [BUF_W-1:0] shown_r, shown_nxt, waiting_r, waiting_nxt, filling_r, filling_nxt;
  logic [ROW_W-1:0] pin_r, pin_nxt, row_r, row_nxt;
  logic lit_r, lit_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic       in_acc;
  opcode_t    op;
  logic [1:0] drv_mode;
  logic       expired, lod_err;
  logic [7:0] px, py, red, green, blue, px_c, py_c;
  logic       adv, rst_rows;
  logic [ROW_W-1:0] pos, scan_row;
  logic [7:0]  offset, addr;
  logic [23:0] pdata;
  logic [1:0]  mreq, treq;
  logic        arm, acc;
  logic [15:0] row_en;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  assign op       = opcode_t'(in_tuser);
  assign drv_mode = in_tdata[1:0];
  assign expired  = in_tdata[2];
  assign lod_err  = in_tdata[3];
  assign px       = in_tdata[11:4];
  assign py       = in_tdata[19:12];
  assign red      = in_tdata[27:20];
  assign green    = in_tdata[35:28];
  assign blue     = in_tdata[43:36];

  // Scan position lit after the current one, then its physical row.
  always_comb begin
    pos = lit_r ? ((row_r == LAST_ROW) ? '0 : row_r + 1'b1) : '0;
    if (!interlaced_r) begin
      scan_row = pos;
    end else if (pos < HALF) begin
      scan_row = ROW_W'({pos, 1'b1});
    end else begin
      scan_row = ROW_W'({pos - HALF, 1'b0});
    end
  end

  assign px_c = (px >= 8'(COLUMNS)) ? MAX_X : px;
  assign py_c = (py >= 8'(ROWS)) ? MAX_Y : py;

  always_comb begin
    seq_nxt       = seq_r;
    dma_phase_nxt = dma_phase_r;
    sched_nxt     = sched_r;
    pend_nxt      = pend_r;
    shown_nxt     = shown_r;
    waiting_nxt   = waiting_r;
    filling_nxt   = filling_r;
    pin_nxt       = pin_r;
    row_nxt       = row_r;
    lit_nxt       = lit_r;
    adv      = 1'b0;
    rst_rows = 1'b0;
    offset   = '0;
    addr     = '0;
    pdata    = '0;
    mreq     = MREQ_NONE;
    treq     = TREQ_NONE;
    arm      = 1'b0;
    acc      = 1'b0;

    unique case (op)
      OP_TICK: begin
        unique case (seq_r)
          ST_SWITCH_EN_WAIT: begin
            if (drv_mode == DRV_ENABLED) begin
              rst_rows = 1'b1;
              seq_nxt  = ST_IDLE;
            end
          end
          ST_IDLE: ;
          ST_LOD, ST_LOD_SWITCH: begin
            mreq    = MREQ_DETECT;
            seq_nxt = ST_LOD_SWITCH_WAIT;
          end
          ST_LOD_SWITCH_WAIT: begin
            if (drv_mode == DRV_DETECT) begin
              rst_rows = 1'b1;
              seq_nxt  = ST_LOD_ADVANCE;
            end
          end
          ST_LOD_ADVANCE: begin
            adv     = 1'b1;
            treq    = TREQ_SETTLE;
            seq_nxt = ST_LOD_SETTLE;
          end
          ST_LOD_SETTLE: begin
            if (expired) begin
              if (lod_err) begin
                treq    = TREQ_ERROR;
                seq_nxt = ST_LOD_ERROR;
              end else begin
                seq_nxt = (row_r == LAST_ROW) ? ST_SWITCH_EN : ST_LOD_ADVANCE;
              end
            end
          end
          ST_LOD_ERROR: begin
            if (expired) begin
              seq_nxt = (row_r == LAST_ROW) ? ST_SWITCH_EN : ST_LOD_ADVANCE;
            end
          end
          default: begin
            mreq    = MREQ_ENABLED;
            seq_nxt = ST_SWITCH_EN_WAIT;
          end
        endcase
      end
      OP_UPDATE: begin
        offset = 8'(scan_row * COLUMNS);
      end
      OP_LATCH: begin
        adv = 1'b1;
      end
      OP_DMA_IDLE: begin
        if (!dma_phase_r) begin
          arm           = 1'b1;
          dma_phase_nxt = 1'b1;
        end else if (!pend_r) begin
          // rotate the finished frame into the waiting slot
          waiting_nxt = filling_r;
          filling_nxt = waiting_r;
          arm         = 1'b1;
          pend_nxt    = 1'b1;
          if (auto_swap_r) begin
            sched_nxt = 1'b1;
          end
        end
      end
      OP_SWAP_REQ: begin
        if (pend_r) begin
          sched_nxt = 1'b1;
          acc       = 1'b1;
        end
      end
      OP_DETECT: begin
        if (seq_r == ST_IDLE) begin
          seq_nxt = ST_LOD;
          acc     = 1'b1;
        end
      end
      OP_DMA_RESET: begin
        sched_nxt     = 1'b0;
        pend_nxt      = 1'b0;
        dma_phase_nxt = 1'b0;
      end
      OP_DRAW: begin
        addr  = 8'(px_c + py_c * COLUMNS);
        pdata = {red, green, blue};
      end
    endcase

    if (rst_rows) begin
      lit_nxt = 1'b0;
      row_nxt = '0;
      pin_nxt = '0;
    end
    if (adv) begin
      row_nxt = pin_r;
      lit_nxt = 1'b1;
      if (pin_r == LAST_ROW) begin
        // last row latched: a scheduled swap takes effect here
        if (sched_r) begin
          shown_nxt   = waiting_r;
          waiting_nxt = shown_r;
          sched_nxt   = 1'b0;
          pend_nxt    = 1'b0;
        end
        pin_nxt = '0;
      end else begin
        pin_nxt = pin_r + 1'b1;
      end
    end

    row_en = lit_nxt ? (16'd1 << row_nxt) : 16'd0;
    out_tdata_nxt = {5'd0, (seq_nxt != ST_IDLE), acc, arm, treq, mreq, pdata, addr,
                     offset, filling_nxt, shown_nxt, row_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interlaced_r <= 1'b0;
      auto_swap_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_INTERLACED) begin
        interlaced_r <= cfg_data;
      end else if (cfg_index == CFG_AUTO_SWAP) begin
        auto_swap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= ST_SWITCH_EN;
      dma_phase_r <= 1'b1;
      sched_r     <= 1'b0;
      pend_r      <= 1'b0;
      shown_r     <= 2'd0;
      waiting_r   <= 2'd1;
      filling_r   <= 2'd2;
      pin_r       <= '0;
      row_r       <= '0;
      lit_r       <= 1'b0;
    end else if (in_acc) begin
      seq_r       <= seq_nxt;
      dma_phase_r <= dma_phase_nxt;
      sched_r     <= sched_nxt;
      pend_r      <= pend_nxt;
      shown_r     <= shown_nxt;
      waiting_r   <= waiting_nxt;
      filling_r   <= filling_nxt;
      pin_r       <= pin_nxt;
      row_r       <= row_nxt;
      lit_r       <= lit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

endmodule

/* tb/sv/scan_ctrl_tb_pkg.sv */
// Event predictor and result scoreboard for the LED row-scan triple-buffer controller bench.
package scan_ctrl_tb_pkg;
  import lrstb_pkg::*;

  localparam int ROWS    = 16;
  localparam int COLUMNS = 16;

  typedef struct {
    opcode_t    op;
    logic [1:0] drv_mode;
    logic       tmr_expired;
    logic       lod_err;
    logic [7:0] px;
    logic [7:0] py;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } scan_event_t;

  typedef struct {
    logic [15:0] row_enable;
    logic [1:0]  display_buf;
    logic [1:0]  receive_buf;
    logic [7:0]  row_offset;
    logic [7:0]  pix_addr;
    logic [23:0] pix_data;
    logic [1:0]  mode_req;
    logic [1:0]  timer_req;
    logic        dma_arm;
    logic        accepted;
    logic        busy;
  } scan_result_t;

  class scan_ctrl_scoreboard;
    bit           interlaced;
    bit           auto_swap;
    seq_state_t   seq;
    bit           dma_receiving;
    bit           swap_sched;
    bit           swap_pend;
    logic [1:0]   shown;
    logic [1:0]   waiting;
    logic [1:0]   filling;
    logic [3:0]   next_pin;
    logic [3:0]   cur_row;
    bit           row_lit;
    scan_result_t expected_results[$];
    int           errors;
    int           detects_taken;
    int           swaps_taken;

    function new();
      interlaced    = 1'b0;
      auto_swap     = 1'b0;
      seq           = ST_SWITCH_EN;
      dma_receiving = 1'b1;
      swap_sched    = 1'b0;
      swap_pend     = 1'b0;
      shown         = 2'd0;
      waiting       = 2'd1;
      filling       = 2'd2;
      clear_rows();
      errors        = 0;
      detects_taken = 0;
      swaps_taken   = 0;
    endfunction

    function void set_config(logic [CFG_IDX_W-1:0] idx, bit val);
      if (idx == CFG_INTERLACED) interlaced = val;
      else if (idx == CFG_AUTO_SWAP) auto_swap = val;
    endfunction

    function void clear_rows();
      row_lit  = 1'b0;
      cur_row  = 4'd0;
      next_pin = 4'd0;
    endfunction

    // Interlaced order lights odd rows in the first half of the scan.
    function logic [3:0] row_of_pos(logic [3:0] pos);
      if (!interlaced) return pos;
      if (pos < ROWS / 2) return 4'(2 * pos + 1);
      return 4'(2 * (pos - ROWS / 2));
    endfunction

    function void advance_row();
      logic [1:0] t;
      cur_row = next_pin;
      row_lit = 1'b1;
      if (cur_row == ROWS - 1) begin
        // a scheduled swap lands on the last row
        if (swap_sched) begin
          t          = shown;
          shown      = waiting;
          waiting    = t;
          swap_sched = 1'b0;
          swap_pend  = 1'b0;
          swaps_taken++;
        end
        next_pin = 4'd0;
      end else begin
        next_pin = cur_row + 4'd1;
      end
    endfunction

    function seq_state_t row_done_state();
      return (cur_row == ROWS - 1) ? ST_SWITCH_EN : ST_LOD_ADVANCE;
    endfunction

    function void note_event(scan_event_t ev);
      scan_result_t r;
      logic [3:0]   pos;
      logic [7:0]   x;
      logic [7:0]   y;
      logic [1:0]   t;
      r = '{default: '0};
      case (ev.op)
        OP_TICK: begin
          case (seq)
            ST_SWITCH_EN_WAIT: begin
              if (ev.drv_mode == DRV_ENABLED) begin
                clear_rows();
                seq = ST_IDLE;
              end
            end
            ST_IDLE: ;
            ST_LOD, ST_LOD_SWITCH: begin
              r.mode_req = MREQ_DETECT;
              seq        = ST_LOD_SWITCH_WAIT;
            end
            ST_LOD_SWITCH_WAIT: begin
              if (ev.drv_mode == DRV_DETECT) begin
                clear_rows();
                seq = ST_LOD_ADVANCE;
              end
            end
            ST_LOD_ADVANCE: begin
              advance_row();
              r.timer_req = TREQ_SETTLE;
              seq         = ST_LOD_SETTLE;
            end
            ST_LOD_SETTLE: begin
              if (ev.tmr_expired) begin
                if (ev.lod_err) begin
                  r.timer_req = TREQ_ERROR;
                  seq         = ST_LOD_ERROR;
                end else begin
                  seq = row_done_state();
                end
              end
            end
            ST_LOD_ERROR: begin
              if (ev.tmr_expired) seq = row_done_state();
            end
            default: begin
              r.mode_req = MREQ_ENABLED;
              seq        = ST_SWITCH_EN_WAIT;
            end
          endcase
        end
        OP_UPDATE: begin
          pos          = row_lit ? cur_row + 4'd1 : 4'd0;
          r.row_offset = 8'(row_of_pos(pos) * COLUMNS);
        end
        OP_LATCH: advance_row();
        OP_DMA_IDLE: begin
          if (!dma_receiving) begin
            r.dma_arm     = 1'b1;
            dma_receiving = 1'b1;
          end else if (!swap_pend) begin
            t         = waiting;
            waiting   = filling;
            filling   = t;
            r.dma_arm = 1'b1;
            swap_pend = 1'b1;
            if (auto_swap) swap_sched = 1'b1;
          end
        end
        OP_SWAP_REQ: begin
          if (swap_pend) begin
            swap_sched = 1'b1;
            r.accepted = 1'b1;
          end
        end
        OP_DETECT: begin
          if (seq == ST_IDLE) begin
            seq        = ST_LOD;
            r.accepted = 1'b1;
            detects_taken++;
          end
        end
        OP_DMA_RESET: begin
          swap_sched    = 1'b0;
          swap_pend     = 1'b0;
          dma_receiving = 1'b0;
        end
        OP_DRAW: begin
          x          = (ev.px >= COLUMNS) ? 8'(COLUMNS - 1) : ev.px;
          y          = (ev.py >= ROWS) ? 8'(ROWS - 1) : ev.py;
          r.pix_addr = 8'(x + y * COLUMNS);
          r.pix_data = {ev.red, ev.green, ev.blue};
        end
      endcase
      r.row_enable  = row_lit ? (16'd1 << cur_row) : 16'd0;
      r.display_buf = shown;
      r.receive_buf = filling;
      r.busy        = (seq != ST_IDLE);
      expected_results.push_back(r);
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(scan_result_t got);
      scan_result_t want;
      if (expected_results.size() == 0) begin
        $error("result item with no event pending");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      cmp("row_enable", 32'(want.row_enable), 32'(got.row_enable));
      cmp("display_buffer", 32'(want.display_buf), 32'(got.display_buf));
      cmp("receive_buffer", 32'(want.receive_buf), 32'(got.receive_buf));
      cmp("row_data_offset", 32'(want.row_offset), 32'(got.row_offset));
      cmp("pixel_address", 32'(want.pix_addr), 32'(got.pix_addr));
      cmp("pixel_data", 32'(want.pix_data), 32'(got.pix_data));
      cmp("mode_request", 32'(want.mode_req), 32'(got.mode_req));
      cmp("timer_request", 32'(want.timer_req), 32'(got.timer_req));
      cmp("dma_arm", 32'(want.dma_arm), 32'(got.dma_arm));
      cmp("accepted", 32'(want.accepted), 32'(got.accepted));
      cmp("busy_res", 32'(want.busy), 32'(got.busy));
    endfunction
  endclass

endpackage

/* tb/sv/tb.sv */
// Top-level bench: drives event items, register writes and output back-pressure.
module tb;
  import lrstb_pkg::*;
  import scan_ctrl_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 90;
  localparam int PHASES       = 5;
  localparam int DRAIN_CYCLES = 4;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AFTER   = 150;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [2:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic                  cfg_data   = 1'b0;

  int cycles         = 0;
  int events_taken   = 0;
  int results_seen   = 0;
  bit no_idle        = 1'b0;
  bit long_hold_done = 1'b0;

  scan_ctrl_scoreboard scan_sb = new();

  led_row_scan_triple_buffer_ctrl uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Sample both handshakes at the rising edge.
  always @(posedge clk) begin
    scan_event_t  ev;
    scan_result_t res;
    if (rst_n && in_tvalid && in_tready) begin
      ev.op          = opcode_t'(in_tuser);
      ev.drv_mode    = in_tdata[1:0];
      ev.tmr_expired = in_tdata[2];
      ev.lod_err     = in_tdata[3];
      ev.px          = in_tdata[11:4];
      ev.py          = in_tdata[19:12];
      ev.red         = in_tdata[27:20];
      ev.green       = in_tdata[35:28];
      ev.blue        = in_tdata[43:36];
      scan_sb.note_event(ev);
      events_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      res.row_enable  = out_tdata[15:0];
      res.display_buf = out_tdata[17:16];
      res.receive_buf = out_tdata[19:18];
      res.row_offset  = out_tdata[27:20];
      res.pix_addr    = out_tdata[35:28];
      res.pix_data    = out_tdata[59:36];
      res.mode_req    = out_tdata[61:60];
      res.timer_req   = out_tdata[63:62];
      res.dma_arm     = out_tdata[64];
      res.accepted    = out_tdata[65];
      res.busy        = out_tdata[66];
      scan_sb.check_result(res);
      results_seen++;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, plus one long hold so the block backs up into its input.
  initial begin : result_sink
    int hold;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      hold = pick_gap();
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  function automatic scan_event_t mk_event(opcode_t op, logic [1:0] mode = 2'd0,
                                           logic expd = 1'b0, logic err = 1'b0,
                                           logic [7:0] x = 8'd0, logic [7:0] y = 8'd0,
                                           logic [7:0] r = 8'd0, logic [7:0] g = 8'd0,
                                           logic [7:0] b = 8'd0);
    scan_event_t ev;
    ev.op          = op;
    ev.drv_mode    = mode;
    ev.tmr_expired = expd;
    ev.lod_err     = err;
    ev.px          = x;
    ev.py          = y;
    ev.red         = r;
    ev.green       = g;
    ev.blue        = b;
    return ev;
  endfunction

  // Bias ticks toward the driver mode the sequencer waits for, so detect walks complete.
  function automatic scan_event_t rand_event();
    int          pick;
    scan_event_t ev;
    pick  = $urandom_range(0, 99);
    ev.op = pick < 40 ? OP_TICK :
            pick < 48 ? OP_UPDATE :
            pick < 60 ? OP_LATCH :
            pick < 70 ? OP_DMA_IDLE :
            pick < 78 ? OP_SWAP_REQ :
            pick < 86 ? OP_DETECT :
            pick < 90 ? OP_DMA_RESET : OP_DRAW;
    ev.drv_mode = 2'($urandom_range(0, 2));
    if ($urandom_range(0, 99) < 85) begin
      if (scan_sb.seq == ST_SWITCH_EN_WAIT) ev.drv_mode = DRV_ENABLED;
      else if (scan_sb.seq == ST_LOD_SWITCH_WAIT) ev.drv_mode = DRV_DETECT;
    end
    ev.tmr_expired = ($urandom_range(0, 99) < 75);
    ev.lod_err     = ($urandom_range(0, 99) < 25);
    ev.px          = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    ev.py          = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    ev.red         = 8'($urandom);
    ev.green       = 8'($urandom);
    ev.blue        = 8'($urandom);
    return ev;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_event(scan_event_t ev);
    in_tuser  <= ev.op;
    in_tdata  <= {4'b0, ev.blue, ev.green, ev.red, ev.py, ev.px,
                  ev.lod_err, ev.tmr_expired, ev.drv_mode};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic pause_input(int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    while (scan_sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_config(bit il, bit as);
    cfg_index <= CFG_INTERLACED;
    cfg_data  <= il;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    scan_sb.set_config(CFG_INTERLACED, il);
    @(negedge clk);
    cfg_index <= CFG_AUTO_SWAP;
    cfg_data  <= as;
    do @(posedge clk); while (!cfg_ready);
    scan_sb.set_config(CFG_AUTO_SWAP, as);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    scan_event_t directed[$];
    bit [1:0]    settings[PHASES];
    // {auto_swap, interlaced} per phase
    settings = '{2'b01, 2'b10, 2'b11, 2'b00, 2'b11};

    directed.push_back(mk_event(OP_TICK));
    directed.push_back(mk_event(OP_TICK));
    directed.push_back(mk_event(OP_TICK, DRV_ENABLED));
    directed.push_back(mk_event(OP_UPDATE));
    directed.push_back(mk_event(OP_LATCH));
    directed.push_back(mk_event(OP_UPDATE));
    directed.push_back(mk_event(OP_DMA_IDLE));
    directed.push_back(mk_event(OP_DMA_IDLE));
    directed.push_back(mk_event(OP_SWAP_REQ));
    directed.push_back(mk_event(OP_DMA_RESET));
    directed.push_back(mk_event(OP_SWAP_REQ));
    directed.push_back(mk_event(OP_DMA_IDLE));
    directed.push_back(mk_event(OP_DETECT));
    directed.push_back(mk_event(OP_DETECT));
    directed.push_back(mk_event(OP_TICK));
    directed.push_back(mk_event(OP_TICK, DRV_ENABLED));
    directed.push_back(mk_event(OP_TICK, DRV_DETECT));
    directed.push_back(mk_event(OP_TICK));
    directed.push_back(mk_event(OP_TICK, 2'd0, 1'b0, 1'b1));
    directed.push_back(mk_event(OP_TICK, 2'd0, 1'b1, 1'b1));
    directed.push_back(mk_event(OP_TICK, 2'd0, 1'b0, 1'b1));
    directed.push_back(mk_event(OP_TICK, 2'd0, 1'b1, 1'b0));
    directed.push_back(mk_event(OP_DRAW));
    directed.push_back(mk_event(OP_DRAW, 2'd3, 1'b1, 1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    directed.push_back(mk_event(OP_DRAW, 2'd0, 1'b0, 1'b0, 8'd16, 8'd200, 8'ha5, 8'h5a, 8'h3c));
    directed.push_back(mk_event(OP_DRAW, 2'd0, 1'b0, 1'b0, 8'd15, 8'd15, 8'h01, 8'h80, 8'h7f));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      send_event(directed[i]);
      pause_input(pick_gap());
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      in_tvalid <= 1'b0;
      drain_results();
      write_config(settings[ph][0], settings[ph][1]);
      no_idle = (ph == 2);
      repeat (PHASE_ITEMS) begin
        send_event(rand_event());
        pause_input(pick_gap());
      end
    end
    in_tvalid <= 1'b0;
    drain_results();

    $display("tb: %0d events taken, %0d results checked over %0d register settings",
             events_taken, results_seen, PHASES + 1);
    $display("tb: %0d open-detect walks started, %0d frame swaps at the last row",
             scan_sb.detects_taken, scan_sb.swaps_taken);
    if (scan_sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
